// File: hw/rtl/sgcd_pkg.sv
// shared types, codes and command pattern table of the stick gesture detector
package sgcd_pkg;

	localparam int STICK_W   = 16;
	localparam int THR_W     = 15;
	localparam int TIME_W    = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;
	localparam int HIST      = 7;
	localparam int NPAT      = 11;
	localparam int NBASE     = 7;

	typedef enum logic [2:0] {
		CLS_CENTER = 3'd0,
		CLS_LEFT   = 3'd1,
		CLS_RIGHT  = 3'd2,
		CLS_DOWN   = 3'd3,
		CLS_UP     = 3'd4,
		CLS_IDLE   = 3'd5,
		CLS_LONG   = 3'd6,
		CLS_OTHER  = 3'd7
	} class_t;

	typedef enum logic [3:0] {
		CMD_NONE = 4'd0,
		CMD_LLD  = 4'd1,
		CMD_RRD  = 4'd2,
		CMD_DDD  = 4'd3,
		CMD_UUU  = 4'd4,
		CMD_RRR  = 4'd5,
		CMD_LLL  = 4'd6,
		CMD_DUD  = 4'd7,
		CMD_UDU  = 4'd8,
		CMD_UDD  = 4'd9,
		CMD_UDR  = 4'd10,
		CMD_UDL  = 4'd11
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STICK_MAX   = 3'd0,
		CFG_STICK_CTR   = 3'd1,
		CFG_HOLD_MIN    = 3'd2,
		CFG_HOLD_LONG   = 3'd3,
		CFG_IDLE_CTR    = 3'd4,
		CFG_TUNING_EN   = 3'd5
	} cfg_idx_t;

	// slot 0 is the newest code
	typedef class_t [HIST-1:0] hist_t;

	typedef struct packed {
		logic   fit;
		class_t cls;
	} cls_res_t;

	typedef struct packed {
		logic hit;
		cmd_t code;
	} match_res_t;

	// oldest entry first
	localparam class_t PAT_TAB [NPAT][HIST] = '{
		'{CLS_IDLE, CLS_LEFT,  CLS_CENTER, CLS_LEFT,  CLS_CENTER, CLS_DOWN,  CLS_CENTER},
		'{CLS_IDLE, CLS_RIGHT, CLS_CENTER, CLS_RIGHT, CLS_CENTER, CLS_DOWN,  CLS_CENTER},
		'{CLS_IDLE, CLS_DOWN,  CLS_CENTER, CLS_DOWN,  CLS_CENTER, CLS_DOWN,  CLS_CENTER},
		'{CLS_IDLE, CLS_UP,    CLS_CENTER, CLS_UP,    CLS_CENTER, CLS_UP,    CLS_CENTER},
		'{CLS_IDLE, CLS_RIGHT, CLS_CENTER, CLS_RIGHT, CLS_CENTER, CLS_RIGHT, CLS_CENTER},
		'{CLS_IDLE, CLS_LEFT,  CLS_CENTER, CLS_LEFT,  CLS_CENTER, CLS_LEFT,  CLS_CENTER},
		'{CLS_IDLE, CLS_DOWN,  CLS_CENTER, CLS_UP,    CLS_CENTER, CLS_DOWN,  CLS_CENTER},
		'{CLS_IDLE, CLS_UP,    CLS_CENTER, CLS_DOWN,  CLS_CENTER, CLS_UP,    CLS_CENTER},
		'{CLS_IDLE, CLS_UP,    CLS_CENTER, CLS_DOWN,  CLS_CENTER, CLS_DOWN,  CLS_CENTER},
		'{CLS_IDLE, CLS_UP,    CLS_CENTER, CLS_DOWN,  CLS_CENTER, CLS_RIGHT, CLS_CENTER},
		'{CLS_IDLE, CLS_UP,    CLS_CENTER, CLS_DOWN,  CLS_CENTER, CLS_LEFT,  CLS_CENTER}
	};

endpackage

// File: hw/rtl/sgcd_if.sv
// valid/ready channel interfaces for stick samples and detected commands
interface sgcd_sample_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [sgcd_pkg::STICK_W-1:0]   roll_stick;
	logic signed [sgcd_pkg::STICK_W-1:0]   pitch_stick;
	logic signed [sgcd_pkg::STICK_W-1:0]   yaw_stick;
	logic                                  on_ground;
	logic        [sgcd_pkg::TIME_W-1:0]    time_us;

	modport source (output valid, roll_stick, pitch_stick, yaw_stick, on_ground, time_us,
		input ready);
	modport sink (input valid, roll_stick, pitch_stick, yaw_stick, on_ground, time_us,
		output ready);
endinterface

interface sgcd_cmd_if;
	logic       valid;
	logic       ready;
	logic [3:0] command_code;

	modport source (output valid, command_code, input ready);
	modport sink (input valid, command_code, output ready);
endinterface

// File: hw/rtl/stick_gesture_command_detector.sv
// top level of the stick gesture command detector
//
//  channel | dir | beat contents                                       | handshake
//  smp     | in  | roll/pitch/yaw stick, on_ground, time_us            | valid/ready
//  cmd     | out | command_code                                        | valid/ready
//  cfg     | in  | cfg_wr_en, cfg_index, cfg_data                      | write enable only
//
//  one beat in, one beat out; registered in the sample register, then the result register
//  a new sample is taken every cycle while the result side keeps up
//  classification, hold timing, history shift and pattern match are combinational from the sample register
//  a stalled result register holds the sample register, which then drops smp.ready
//  reset loads the default thresholds and clears history to center
module stick_gesture_command_detector (
	input  logic                                clk,
	input  logic                                arst_n,
	sgcd_sample_if.sink                         smp,
	sgcd_cmd_if.source                          cmd,
	input  logic                                cfg_wr_en,
	input  logic [sgcd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sgcd_pkg::CFG_DAT_W-1:0]      cfg_data
);

	// configuration
	logic [sgcd_pkg::THR_W-1:0]  stick_max_q, stick_ctr_q;
	logic [sgcd_pkg::TIME_W-1:0] hold_min_q, hold_long_q, idle_ctr_q;
	logic                        tuning_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stick_max_q <= 15'd11469;
			stick_ctr_q <= 15'd3277;
			hold_min_q  <= 32'd100000;
			hold_long_q <= 32'd500000;
			idle_ctr_q  <= 32'd700000;
			tuning_q    <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (sgcd_pkg::cfg_idx_t'(cfg_index))
				sgcd_pkg::CFG_STICK_MAX: stick_max_q <= cfg_data[sgcd_pkg::THR_W-1:0];
				sgcd_pkg::CFG_STICK_CTR: stick_ctr_q <= cfg_data[sgcd_pkg::THR_W-1:0];
				sgcd_pkg::CFG_HOLD_MIN:  hold_min_q  <= cfg_data[sgcd_pkg::TIME_W-1:0];
				sgcd_pkg::CFG_HOLD_LONG: hold_long_q <= cfg_data[sgcd_pkg::TIME_W-1:0];
				sgcd_pkg::CFG_IDLE_CTR:  idle_ctr_q  <= cfg_data[sgcd_pkg::TIME_W-1:0];
				sgcd_pkg::CFG_TUNING_EN: tuning_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sample register
	logic                                valid_s1;
	logic signed [sgcd_pkg::STICK_W-1:0] roll_s1, pitch_s1, yaw_s1;
	logic                                ground_s1;
	logic        [sgcd_pkg::TIME_W-1:0]  time_s1;
	logic                                out_valid_q;
	sgcd_pkg::cmd_t                      cmd_q;
	logic                                adv;
	logic                                in_acc;

	assign adv       = valid_s1 && (!out_valid_q || cmd.ready);
	assign smp.ready = !valid_s1 || adv;
	assign in_acc    = smp.valid && smp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			roll_s1   <= smp.roll_stick;
			pitch_s1  <= smp.pitch_stick;
			yaw_s1    <= smp.yaw_stick;
			ground_s1 <= smp.on_ground;
			time_s1   <= smp.time_us;
		end
	end

	// detector state
	sgcd_pkg::class_t            cur_q, prev_q, commit_q;
	logic [sgcd_pkg::TIME_W-1:0] start_q;
	sgcd_pkg::hist_t             hist_q;

	sgcd_pkg::cls_res_t   cls_res;
	sgcd_pkg::match_res_t match_res;
	sgcd_pkg::class_t     cls_new, commit_new, prev_new, cur_new;
	logic [sgcd_pkg::TIME_W-1:0] diff, dur, start_new;
	logic                 changed, shift;
	sgcd_pkg::hist_t      hist_sh, hist_new;
	sgcd_pkg::cmd_t       cmd_new;

	sgcd_classify u_classify (
		.roll  (roll_s1),
		.pitch (pitch_s1),
		.yaw   (yaw_s1),
		.smax  (stick_max_q),
		.scen  (stick_ctr_q),
		.res   (cls_res)
	);

	sgcd_match u_match (
		.hist      (hist_sh),
		.tuning_en (tuning_q),
		.res       (match_res)
	);

	always_comb begin
		cls_new = cls_res.fit ? cls_res.cls : cur_q;
		changed = cls_new != prev_q;
		diff    = time_s1 - start_q;
		dur     = changed ? '0 : diff;

		commit_new = commit_q;
		if (dur > hold_min_q) begin
			if (cls_new == sgcd_pkg::CLS_CENTER && dur > idle_ctr_q) begin
				commit_new = sgcd_pkg::CLS_IDLE;
			end else if (dur > hold_long_q) begin
				commit_new = sgcd_pkg::CLS_LONG;
			end else begin
				commit_new = cls_new;
			end
		end

		hist_sh = sgcd_pkg::hist_t'({hist_q[sgcd_pkg::HIST-2:0], commit_new});
		shift   = commit_new != hist_q[0];

		cur_new   = cur_q;
		prev_new  = sgcd_pkg::CLS_OTHER;
		start_new = start_q;
		hist_new  = hist_q;
		cmd_new   = sgcd_pkg::CMD_NONE;
		if (ground_s1) begin
			cur_new   = cls_new;
			prev_new  = cls_new;
			start_new = changed ? time_s1 : start_q;
			if (shift) begin
				hist_new = hist_sh;
				if (match_res.hit) begin
					hist_new[1] = sgcd_pkg::CLS_OTHER;
				end
				cmd_new = match_res.code;
			end
		end else begin
			commit_new = sgcd_pkg::CLS_OTHER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q    <= sgcd_pkg::CLS_CENTER;
			prev_q   <= sgcd_pkg::CLS_CENTER;
			commit_q <= sgcd_pkg::CLS_CENTER;
			start_q  <= '0;
			hist_q   <= sgcd_pkg::hist_t'({sgcd_pkg::HIST{sgcd_pkg::CLS_CENTER}});
		end else if (adv) begin
			cur_q    <= cur_new;
			prev_q   <= prev_new;
			commit_q <= commit_new;
			start_q  <= start_new;
			hist_q   <= hist_new;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (cmd.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_q <= cmd_new;
		end
	end

	assign cmd.valid        = out_valid_q;
	assign cmd.command_code = cmd_q;

	// checks
	a_tuning_gate: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !tuning_q |-> cmd_q <= sgcd_pkg::CMD_DUD)
		else $error("tuning command reported while tuning disabled");

	a_hit_marks_slot1: assert property (@(posedge clk) disable iff (!arst_n)
		adv && cmd_new != sgcd_pkg::CMD_NONE |=> hist_q[1] == sgcd_pkg::CLS_OTHER)
		else $error("history slot 1 not marked after a command");

	a_off_ground: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !ground_s1 |=> commit_q == sgcd_pkg::CLS_OTHER && prev_q == sgcd_pkg::CLS_OTHER
		&& cmd_q == sgcd_pkg::CMD_NONE)
		else $error("off-ground beat did not force other");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1)
		else $error("sample register lost a beat");

endmodule

// File: hw/rtl/sgcd_classify.sv
// stick sample classifier: center, left, right, down or up by strict thresholds, else no fit (other)
module sgcd_classify (
	input  logic signed [sgcd_pkg::STICK_W-1:0] roll,
	input  logic signed [sgcd_pkg::STICK_W-1:0] pitch,
	input  logic signed [sgcd_pkg::STICK_W-1:0] yaw,
	input  logic        [sgcd_pkg::THR_W-1:0]   smax,
	input  logic        [sgcd_pkg::THR_W-1:0]   scen,
	output sgcd_pkg::cls_res_t                  res
);

	logic signed [sgcd_pkg::STICK_W:0] roll_e, pitch_e, yaw_e;
	logic signed [sgcd_pkg::STICK_W:0] roll_m, pitch_m, yaw_m;
	logic signed [sgcd_pkg::STICK_W:0] smax_e, nmax_e, scen_e;
	logic left, right, down, up, xcen, pcen;

	always_comb begin
		roll_e  = (sgcd_pkg::STICK_W+1)'(roll);
		pitch_e = (sgcd_pkg::STICK_W+1)'(pitch);
		yaw_e   = (sgcd_pkg::STICK_W+1)'(yaw);
		roll_m  = roll_e  < 0 ? -roll_e  : roll_e;
		pitch_m = pitch_e < 0 ? -pitch_e : pitch_e;
		yaw_m   = yaw_e   < 0 ? -yaw_e   : yaw_e;
		smax_e  = signed'({2'b00, smax});
		scen_e  = signed'({2'b00, scen});
		nmax_e  = -smax_e;

		left  = roll_e < nmax_e || yaw_e < nmax_e;
		right = roll_e > smax_e || yaw_e > smax_e;
		xcen  = roll_m < scen_e && yaw_m < scen_e;
		pcen  = pitch_m < scen_e;
		down  = pitch_e < nmax_e;
		up    = pitch_e > smax_e;

		res.fit = 1'b1;
		if (xcen && pcen) begin
			res.cls = sgcd_pkg::CLS_CENTER;
		end else if (left && pcen) begin
			res.cls = sgcd_pkg::CLS_LEFT;
		end else if (right && pcen) begin
			res.cls = sgcd_pkg::CLS_RIGHT;
		end else if (down && xcen) begin
			res.cls = sgcd_pkg::CLS_DOWN;
		end else if (up && xcen) begin
			res.cls = sgcd_pkg::CLS_UP;
		end else begin
			res.fit = 1'b0;
			res.cls = sgcd_pkg::CLS_OTHER;
		end
	end

endmodule

// File: hw/rtl/sgcd_match.sv
// command pattern matcher over the seven-deep code history
module sgcd_match (
	input  sgcd_pkg::hist_t      hist,
	input  logic                 tuning_en,
	output sgcd_pkg::match_res_t res
);

	logic [sgcd_pkg::NPAT-1:0] pat_hit;

	always_comb begin
		for (int p = 0; p < sgcd_pkg::NPAT; p++) begin
			pat_hit[p] = 1'b1;
			for (int i = 0; i < sgcd_pkg::HIST; i++) begin
				if (hist[i] != sgcd_pkg::PAT_TAB[p][sgcd_pkg::HIST-1-i]) begin
					pat_hit[p] = 1'b0;
				end
			end
			if (p >= sgcd_pkg::NBASE && !tuning_en) begin
				pat_hit[p] = 1'b0;
			end
		end
	end

	// lowest pattern wins
	always_comb begin
		res.hit  = 1'b0;
		res.code = sgcd_pkg::CMD_NONE;
		for (int p = sgcd_pkg::NPAT-1; p >= 0; p--) begin
			if (pat_hit[p]) begin
				res.hit  = 1'b1;
				res.code = sgcd_pkg::cmd_t'(4'(p + 1));
			end
		end
	end

endmodule

// File: verif/tb.sv
// testbench for the stick gesture command detector: gesture sequences and noise checked against a predictor
`timescale 1ns / 100ps

module tb;
	import sgcd_pkg::*;

	typedef struct packed {
		logic signed [STICK_W-1:0] roll;
		logic signed [STICK_W-1:0] pitch;
		logic signed [STICK_W-1:0] yaw;
		logic                      ground;
		logic [TIME_W-1:0]         time_us;
	} stick_beat_t;

	typedef struct packed {
		logic        typed;
		cmd_t        want;
		stick_beat_t beat;
	} dir_row_t;

	localparam class_t GESTURE_PAT [NPAT][HIST] = '{
		'{CLS_IDLE, CLS_LEFT,  CLS_CENTER, CLS_LEFT,  CLS_CENTER, CLS_DOWN,  CLS_CENTER},
		'{CLS_IDLE, CLS_RIGHT, CLS_CENTER, CLS_RIGHT, CLS_CENTER, CLS_DOWN,  CLS_CENTER},
		'{CLS_IDLE, CLS_DOWN,  CLS_CENTER, CLS_DOWN,  CLS_CENTER, CLS_DOWN,  CLS_CENTER},
		'{CLS_IDLE, CLS_UP,    CLS_CENTER, CLS_UP,    CLS_CENTER, CLS_UP,    CLS_CENTER},
		'{CLS_IDLE, CLS_RIGHT, CLS_CENTER, CLS_RIGHT, CLS_CENTER, CLS_RIGHT, CLS_CENTER},
		'{CLS_IDLE, CLS_LEFT,  CLS_CENTER, CLS_LEFT,  CLS_CENTER, CLS_LEFT,  CLS_CENTER},
		'{CLS_IDLE, CLS_DOWN,  CLS_CENTER, CLS_UP,    CLS_CENTER, CLS_DOWN,  CLS_CENTER},
		'{CLS_IDLE, CLS_UP,    CLS_CENTER, CLS_DOWN,  CLS_CENTER, CLS_UP,    CLS_CENTER},
		'{CLS_IDLE, CLS_UP,    CLS_CENTER, CLS_DOWN,  CLS_CENTER, CLS_DOWN,  CLS_CENTER},
		'{CLS_IDLE, CLS_UP,    CLS_CENTER, CLS_DOWN,  CLS_CENTER, CLS_RIGHT, CLS_CENTER},
		'{CLS_IDLE, CLS_UP,    CLS_CENTER, CLS_DOWN,  CLS_CENTER, CLS_LEFT,  CLS_CENTER}
	};

	localparam dir_row_t DIR_TAB [23] = '{
		'{1'b1, CMD_NONE, '{16'sh8000, 16'sh7FFF, -16'sd16384, 1'b0, 32'hFFFF_FFFF}},
		'{1'b0, CMD_NONE, '{16'sd0, 16'sd0, 16'sd0, 1'b1, 32'd0}},
		'{1'b0, CMD_NONE, '{16'sd0, 16'sd0, 16'sd0, 1'b1, 32'd800000}},
		'{1'b0, CMD_NONE, '{-16'sd16384, 16'sd0, 16'sd0, 1'b1, 32'd800001}},
		'{1'b0, CMD_NONE, '{-16'sd16384, 16'sd0, 16'sd0, 1'b1, 32'd900002}},
		'{1'b0, CMD_NONE, '{16'sd0, 16'sd0, 16'sd0, 1'b1, 32'd900003}},
		'{1'b0, CMD_NONE, '{16'sd0, 16'sd0, 16'sd0, 1'b1, 32'd1000004}},
		'{1'b0, CMD_NONE, '{16'sd0, 16'sd0, -16'sd12000, 1'b1, 32'd1000005}},
		'{1'b0, CMD_NONE, '{16'sd0, 16'sd0, -16'sd12000, 1'b1, 32'd1100006}},
		'{1'b0, CMD_NONE, '{16'sd3276, 16'sd0, -16'sd3276, 1'b1, 32'd1100007}},
		'{1'b0, CMD_NONE, '{16'sd0, -16'sd3276, 16'sd0, 1'b1, 32'd1200008}},
		'{1'b0, CMD_NONE, '{16'sd0, -16'sd16384, 16'sd0, 1'b1, 32'd1200009}},
		'{1'b0, CMD_NONE, '{16'sd0, -16'sd11470, 16'sd0, 1'b1, 32'd1300010}},
		'{1'b0, CMD_NONE, '{16'sd0, 16'sd0, 16'sd0, 1'b1, 32'd1300011}},
		'{1'b1, CMD_LLD,  '{16'sd0, 16'sd0, 16'sd0, 1'b1, 32'd1400012}},
		'{1'b0, CMD_NONE, '{16'sh7FFF, 16'sd0, 16'sd0, 1'b1, 32'd1400013}},
		'{1'b0, CMD_NONE, '{16'sd0, 16'sd16384, 16'sd0, 1'b1, 32'hFFFF_FFFF}},
		'{1'b0, CMD_NONE, '{16'sd0, 16'sd0, 16'sh8000, 1'b1, 32'd0}},
		'{1'b0, CMD_NONE, '{16'sd16384, 16'sd16384, 16'sd0, 1'b1, 32'd5}},
		'{1'b0, CMD_NONE, '{16'sd3277, 16'sd0, 16'sd0, 1'b1, 32'd6}},
		'{1'b0, CMD_NONE, '{16'sd11469, 16'sd0, 16'sd0, 1'b1, 32'd7}},
		'{1'b0, CMD_NONE, '{16'sd11470, 16'sd0, 16'sd0, 1'b1, 32'd8}},
		'{1'b1, CMD_NONE, '{16'sd16384, 16'sd0, 16'sd0, 1'b0, 32'd9}}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	sgcd_sample_if smp();
	sgcd_cmd_if    cmd();

	stick_gesture_command_detector i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp       (smp),
		.cmd       (cmd),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	logic [THR_W-1:0]  thr_max  = 15'd11469;
	logic [THR_W-1:0]  thr_ctr  = 15'd3277;
	logic [TIME_W-1:0] min_us   = 32'd100000;
	logic [TIME_W-1:0] long_us  = 32'd500000;
	logic [TIME_W-1:0] idle_us  = 32'd700000;
	logic              tune_en  = 1'b0;

	class_t            cls_now   = CLS_CENTER;
	class_t            cls_prev  = CLS_CENTER;
	class_t            code_held = CLS_CENTER;
	logic [TIME_W-1:0] t_start   = '0;
	class_t            code_hist [HIST] = '{default: CLS_CENTER};

	cmd_t              cmd_due_q [$];
	logic [TIME_W-1:0] t_cursor;
	int                beats_sent;
	int                beats_seen;
	int                bad_beats;
	bit                tx_burst;
	bit                rx_burst;
	bit                pressure_done;

	function automatic cmd_t detect_command(stick_beat_t b);
		int                r;
		int                p;
		int                y;
		int                smax;
		int                scen;
		bit                defl_l;
		bit                defl_r;
		bit                defl_d;
		bit                defl_u;
		bit                ctr_x;
		bit                ctr_p;
		bit                hit;
		int                npat;
		logic [TIME_W-1:0] d;
		cmd_t              res;
		res = CMD_NONE;
		if (b.ground) begin
			r = int'(b.roll);
			p = int'(b.pitch);
			y = int'(b.yaw);
			smax = int'(thr_max);
			scen = int'(thr_ctr);
			defl_l = r < -smax || y < -smax;
			defl_r = r > smax || y > smax;
			ctr_x = (r < 0 ? -r : r) < scen && (y < 0 ? -y : y) < scen;
			ctr_p = (p < 0 ? -p : p) < scen;
			defl_d = p < -smax;
			defl_u = p > smax;
			if (ctr_x && ctr_p) cls_now = CLS_CENTER;
			else if (defl_l && ctr_p) cls_now = CLS_LEFT;
			else if (defl_r && ctr_p) cls_now = CLS_RIGHT;
			else if (defl_d && ctr_x) cls_now = CLS_DOWN;
			else if (defl_u && ctr_x) cls_now = CLS_UP;
			if (cls_now != cls_prev) t_start = b.time_us;
			d = b.time_us - t_start;
			if (d > min_us) begin
				if (cls_now == CLS_CENTER && d > idle_us) code_held = CLS_IDLE;
				else if (d > long_us) code_held = CLS_LONG;
				else code_held = cls_now;
			end
			cls_prev = cls_now;
			if (code_held != code_hist[0]) begin
				for (int i = HIST - 1; i >= 1; i--) code_hist[i] = code_hist[i-1];
				code_hist[0] = code_held;
				npat = tune_en ? NPAT : NBASE;
				for (int k = 0; k < npat && res == CMD_NONE; k++) begin
					hit = 1'b1;
					for (int i = 0; i < HIST; i++)
						if (code_hist[i] != GESTURE_PAT[k][HIST-1-i]) hit = 1'b0;
					if (hit) begin
						code_hist[1] = CLS_OTHER;
						res = cmd_t'(k + 1);
					end
				end
			end
		end else begin
			code_held = CLS_OTHER;
			cls_prev = CLS_OTHER;
		end
		return res;
	endfunction

	function automatic logic signed [STICK_W-1:0] ctr_val();
		int v;
		if (thr_ctr == 0) return '0;
		v = $urandom_range(0, thr_ctr - 1);
		return $urandom_range(0, 1) ? 16'(-v) : 16'(v);
	endfunction

	function automatic logic signed [STICK_W-1:0] defl_val();
		int top;
		top = (thr_max < 15'd16384) ? 16384 : 32767;
		return 16'($urandom_range(thr_max + 1, top));
	endfunction

	function automatic stick_beat_t noise_beat();
		stick_beat_t b;
		b.roll = 16'($urandom);
		b.pitch = 16'($urandom);
		b.yaw = 16'($urandom);
		b.ground = 1'($urandom);
		b.time_us = $urandom;
		return b;
	endfunction

	function automatic stick_beat_t beat_for(class_t c);
		stick_beat_t             b;
		logic signed [STICK_W-1:0] d;
		b.roll = ctr_val();
		b.pitch = ctr_val();
		b.yaw = ctr_val();
		b.ground = 1'b1;
		b.time_us = t_cursor;
		d = defl_val();
		case (c)
			CLS_LEFT: begin
				if ($urandom_range(0, 1)) b.roll = -d;
				else b.yaw = -d;
			end
			CLS_RIGHT: begin
				if ($urandom_range(0, 1)) b.roll = d;
				else b.yaw = d;
			end
			CLS_DOWN: b.pitch = -d;
			CLS_UP: b.pitch = d;
			CLS_CENTER, CLS_IDLE: ;
			default: begin
				b = noise_beat();
				b.time_us = t_cursor;
			end
		endcase
		return b;
	endfunction

	task automatic send_beat(input stick_beat_t b, input logic typed, input cmd_t want);
		int   gap;
		cmd_t guess;
		if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
		gap = tx_burst ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			smp.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		smp.valid <= 1'b1;
		smp.roll_stick <= b.roll;
		smp.pitch_stick <= b.pitch;
		smp.yaw_stick <= b.yaw;
		smp.on_ground <= b.ground;
		smp.time_us <= b.time_us;
		guess = detect_command(b);
		cmd_due_q.push_back(typed ? want : guess);
		beats_sent++;
		do @(posedge clk); while (!smp.ready);
	endtask

	task automatic reg_write(input cfg_idx_t idx, input logic [CFG_DAT_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_STICK_MAX: thr_max = val[THR_W-1:0];
			CFG_STICK_CTR: thr_ctr = val[THR_W-1:0];
			CFG_HOLD_MIN: min_us = val;
			CFG_HOLD_LONG: long_us = val;
			CFG_IDLE_CTR: idle_us = val;
			CFG_TUNING_EN: tune_en = val[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic write_regs(input logic [THR_W-1:0] smax, input logic [THR_W-1:0] scen,
		input logic [TIME_W-1:0] hmin, input logic [TIME_W-1:0] hlong,
		input logic [TIME_W-1:0] hidle, input logic ten);
		reg_write(CFG_STICK_MAX, 32'(smax));
		reg_write(CFG_STICK_CTR, 32'(scen));
		reg_write(CFG_HOLD_MIN, hmin);
		reg_write(CFG_HOLD_LONG, hlong);
		reg_write(CFG_IDLE_CTR, hidle);
		reg_write(CFG_TUNING_EN, 32'(ten));
		cfg_wr_en <= 1'b0;
	endtask

	task automatic hold_code(input class_t c);
		stick_beat_t       b;
		longint            hi;
		longint            hold;
		longint            span;
		logic [TIME_W-1:0] seg;
		b = beat_for(c);
		t_cursor += 32'($urandom_range(1, 4));
		b.time_us = t_cursor;
		send_beat(b, 1'b0, CMD_NONE);
		seg = t_cursor;
		if (c == CLS_IDLE) begin
			hold = longint'(min_us > idle_us ? min_us : idle_us) + 1 + $urandom_range(0, 50);
		end else begin
			hi = longint'(long_us);
			if (c == CLS_CENTER && longint'(idle_us) < hi) hi = longint'(idle_us);
			span = hi - longint'(min_us) - 1;
			if (span >= 0) hold = longint'(min_us) + 1 + $urandom_range(0, span > 2000 ? 2000 : span);
			else hold = longint'(min_us) + 1 + $urandom_range(0, 50);
		end
		if (min_us > 1 && $urandom_range(0, 2) == 0) begin
			b = beat_for(c);
			b.time_us = seg + $urandom_range(1, min_us > 1000 ? 1000 : min_us);
			send_beat(b, 1'b0, CMD_NONE);
		end
		b = beat_for(c);
		b.time_us = seg + 32'(hold);
		t_cursor = b.time_us;
		send_beat(b, 1'b0, CMD_NONE);
	endtask

	task automatic send_gesture(input int pat, input bit spoil);
		int     bad_at;
		class_t c;
		bad_at = spoil ? $urandom_range(0, HIST - 1) : -1;
		for (int k = 0; k < HIST; k++) begin
			c = GESTURE_PAT[pat][k];
			if (k == bad_at) c = class_t'($urandom_range(0, 4));
			hold_code(c);
		end
	endtask

	task automatic drain();
		smp.valid <= 1'b0;
		@(posedge clk);
		while (cmd_due_q.size() != 0) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("** stick_gesture_command_detector: FAILED **");
		$finish;
	end

	initial begin : rx_side
		int   stall;
		cmd_t want;
		cmd.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = rx_burst ? 0 : $urandom_range(0, 11);
			if (beats_seen == 400 && !pressure_done) begin
				stall = 300;
				pressure_done = 1'b1;
			end
			if (stall > 0) begin
				cmd.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			cmd.ready <= 1'b1;
			do @(posedge clk); while (!cmd.valid);
			beats_seen++;
			if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
			if (cmd_due_q.size() == 0) begin
				bad_beats++;
				if (bad_beats <= 10)
					$display("%0t: unexpected command beat, got %0d", $realtime, cmd.command_code);
			end else begin
				want = cmd_due_q.pop_front();
				if (cmd.command_code !== want) begin
					bad_beats++;
					if (bad_beats <= 10)
						$display("%0t: command_code expected %0d got %0d", $realtime,
							want, cmd.command_code);
				end
			end
		end
	end

	initial begin : tx_side
		stick_beat_t       b;
		int                stop_at;
		logic [THR_W-1:0]  smax;
		logic [THR_W-1:0]  scen;
		logic [TIME_W-1:0] hmin;
		logic [TIME_W-1:0] hlong;
		logic [TIME_W-1:0] hidle;
		logic              ten;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		smp.valid <= 1'b0;
		smp.roll_stick <= '0;
		smp.pitch_stick <= '0;
		smp.yaw_stick <= '0;
		smp.on_ground <= 1'b0;
		smp.time_us <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIR_TAB[i]) send_beat(DIR_TAB[i].beat, DIR_TAB[i].typed, DIR_TAB[i].want);
		drain();

		for (int ph = 1; ph <= 7; ph++) begin
			case (ph)
				1: write_regs(15'd16384, 15'd0, 32'd0, 32'd0, 32'd0, 1'b1);
				2: write_regs(15'd0, 15'd16384, '1, '1, '1, 1'b0);
				default: begin
					smax = 15'($urandom_range(6000, 16384));
					scen = 15'($urandom_range(1, 5000));
					hmin = $urandom_range(0, 3000);
					hlong = hmin + $urandom_range(1, 6000);
					hidle = hmin + $urandom_range(1, 9000);
					ten = (ph == 3) ? 1'b1 : (ph == 4) ? 1'b0 : 1'($urandom_range(0, 1));
					if (ph == 7) hlong = hmin / 2;
					write_regs(smax, scen, hmin, hlong, hidle, ten);
				end
			endcase
			stop_at = beats_sent + (ph <= 2 ? 150 : 220);
			t_cursor = $urandom;
			while (beats_sent < stop_at) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5, 6: send_gesture($urandom_range(0, NPAT - 1),
						$urandom_range(0, 5) == 0);
					7: repeat ($urandom_range(1, 4)) begin
						t_cursor += $urandom_range(0, 2000);
						b = beat_for(class_t'($urandom_range(0, 4)));
						send_beat(b, 1'b0, CMD_NONE);
					end
					8: begin
						b = noise_beat();
						b.ground = 1'b0;
						t_cursor += $urandom_range(0, 2000);
						b.time_us = t_cursor;
						send_beat(b, 1'b0, CMD_NONE);
					end
					default: send_beat(noise_beat(), 1'b0, CMD_NONE);
				endcase
			end
			drain();
		end

		repeat (8) @(posedge clk);
		if (bad_beats == 0)
			$display("** stick_gesture_command_detector: PASSED **");
		else
			$display("** stick_gesture_command_detector: FAILED **");
		$finish;
	end

endmodule
